FILE: rtl/core/nearest_key_snap_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest key snap table
// Shared implication forms used by the core module of the block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_KEY_SNAP_TABLE_CORE_ASSERT_SVH
`define NEAREST_KEY_SNAP_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NKS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nks: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NKS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nks: next-cycle check failed");

`endif

FILE: rtl/core/nks_pkg.sv
// ----------------------------------------------------------------------------
// Nearest key snap table package
// Sizes, entry record, sequencer states and action codes of the block.
// ----------------------------------------------------------------------------
package nks_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int POS_W       = 24;
   localparam int BEND_W      = 16;
   localparam int ROLL_W      = 17;
   localparam int SNAP_W      = 20;
   localparam int MATCH_IDX_W = 6;
   localparam int ENT_CNT_W   = 7;
   localparam int ACTION_W    = 3;

   localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(500);

   typedef struct packed {
      logic        [POS_W-1:0]  position;
      logic signed [BEND_W-1:0] bend;
      logic signed [ROLL_W-1:0] roll;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE     = 3'd0,
      ACT_UPDATED  = 3'd1,
      ACT_INSERTED = 3'd2,
      ACT_REMOVED  = 3'd3,
      ACT_REJECTED = 3'd4
   } action_type;

endpackage

FILE: rtl/core/nks_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module nks_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/nks_dist_unit.sv
// ----------------------------------------------------------------------------
// Distance compare unit
// Absolute position difference and compare against the best distance so far.
// ----------------------------------------------------------------------------
module nks_dist_unit (
   input  logic [nks_pkg::POS_W-1:0] entry_pos,
   input  logic [nks_pkg::POS_W-1:0] req_pos,
   input  logic [nks_pkg::POS_W-1:0] best_dist,
   output logic [nks_pkg::POS_W-1:0] abs_diff,
   output logic                      hit
);
   import nks_pkg::*;

   // An equal distance is a hit, so a later index replaces an earlier one.
   always_comb begin
      if (entry_pos >= req_pos) begin
         abs_diff = entry_pos - req_pos;
      end else begin
         abs_diff = req_pos - entry_pos;
      end
      hit = (abs_diff <= best_dist);
   end

endmodule

FILE: rtl/core/nearest_key_snap_table_core.sv
// ----------------------------------------------------------------------------
// Nearest key snap table core
// Holds up to MAX_ENTRIES position/bend/roll records and serves query and
// set items by a sequential nearest-match scan.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low;
// req_type selects a query (0) or a set (1). Busy stays high until the
// result has been shown. Each result is on the rsp_ ports for exactly one
// cycle, marked by rsp_valid, and the receiver cannot stall it.
// All records live in one RAM with a registered read port. The scan reads
// one entry per cycle and feeds the single distance compare unit. The
// decide state follows, where an update or insert writes the RAM. A
// removal then moves the later entries down one place through the same
// RAM port pair. The response state ends the sequence, and busy falls in
// the cycle after the result is shown, so a new item is taken only once
// the last one is through. Synchronous reset empties the table and sets
// the snap distance to 500; the RAM content is not cleared since only
// entries below the count are ever read. The user must write the snap
// distance through csr_wr_en and csr_wr_data only while idle; the block
// does not enforce this.
// ----------------------------------------------------------------------------
`include "nearest_key_snap_table_core_assert.svh"

module nearest_key_snap_table_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic [nks_pkg::POS_W-1:0]           req_position,
   input  logic signed [nks_pkg::BEND_W-1:0]   req_bend_angle,
   input  logic signed [nks_pkg::ROLL_W-1:0]   req_roll_angle,
   input  logic                                csr_wr_en,
   input  logic [nks_pkg::SNAP_W-1:0]          csr_wr_data,
   output logic                                rsp_valid,
   output logic                                rsp_match_found,
   output logic [nks_pkg::MATCH_IDX_W-1:0]     rsp_match_index,
   output logic [nks_pkg::ACTION_W-1:0]        rsp_action,
   output logic [nks_pkg::ENT_CNT_W-1:0]       rsp_entry_count
);
   import nks_pkg::*;

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SNAP_W-1:0]  snap_ff;
   logic [POS_W-1:0]   best_ff, best_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   midx_ff, midx_in;
   action_type         action_ff, action_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_addr_ff, pend_addr_in;

   // The accepted item is held for the whole sequence.
   logic               req_type_ff;
   entry_type          req_ff;

   // RAM port signals.
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   entry_type          ram_rd_data;

   logic [POS_W-1:0]   dist_val;
   logic               dist_hit;
   logic               accept;
   logic [CNT_W-1:0]   scan_dec;
   logic               shift_wr;
   logic               resp_insert;

   assign accept   = start && (state_ff == ST_IDLE);
   assign scan_dec = scan_ff - CNT_W'(1);

   nks_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   nks_dist_unit u_dist (
      .entry_pos (ram_rd_data.position),
      .req_pos   (req_ff.position),
      .best_dist (best_ff),
      .abs_diff  (dist_val),
      .hit       (dist_hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // All reads issued and the last compare done.
            if ((scan_ff == count_ff) && !cmp_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (req_type_ff && (req_ff.bend == '0) && found_ff) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            if ((scan_ff > count_ff) && !pend_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath next values and RAM control.
   always_comb begin
      count_in     = count_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      midx_in      = midx_ff;
      action_in    = action_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = scan_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               best_in   = POS_W'(snap_ff);
               found_in  = 1'b0;
               midx_in   = '0;
               action_in = ACT_NONE;
               scan_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && dist_hit) begin
               best_in  = dist_val;
               found_in = 1'b1;
               midx_in  = cmp_idx_ff;
            end
            if (scan_ff != count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end
         ST_DECIDE: begin
            ram_wr_data = req_ff;
            if (req_type_ff) begin
               if (req_ff.bend == '0) begin
                  if (found_ff) begin
                     // The count drops now; entries after the match move down.
                     action_in = ACT_REMOVED;
                     count_in  = count_ff - CNT_W'(1);
                     scan_in   = CNT_W'(midx_ff) + CNT_W'(1);
                  end
               end else if (found_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = midx_ff;
                  action_in   = ACT_UPDATED;
               end else if (count_ff == CNT_W'(MAX_ENTRIES)) begin
                  action_in = ACT_REJECTED;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[IDX_W-1:0];
                  count_in    = count_ff + CNT_W'(1);
                  action_in   = ACT_INSERTED;
               end
            end
         end
         ST_SHIFT: begin
            // Read entry k while the previously read entry k - 1 lands at k - 2.
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if (scan_ff <= count_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = scan_dec[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         snap_ff    <= SNAP_RESET;
         cmp_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
         found_ff   <= 1'b0;
         action_ff  <= ACT_NONE;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         pend_ff    <= pend_in;
         found_ff   <= found_in;
         action_ff  <= action_in;
         if (csr_wr_en) begin
            snap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      midx_ff      <= midx_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      pend_addr_ff <= pend_addr_in;
      if (accept) begin
         req_type_ff     <= req_type;
         req_ff.position <= req_position;
         req_ff.bend     <= req_bend_angle;
         req_ff.roll     <= req_roll_angle;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_match_found = found_ff;
   assign rsp_match_index = MATCH_IDX_W'(midx_ff);
   assign rsp_action      = action_ff;
   assign rsp_entry_count = ENT_CNT_W'(count_ff);

   assign shift_wr    = ram_wr_en && (state_ff == ST_SHIFT);
   assign resp_insert = rsp_valid && (action_ff == ACT_INSERTED);

   `NKS_ASSERT_NXT(a_resp_then_idle, clock, reset, rsp_valid, !busy)
   `NKS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `NKS_ASSERT_IMP(a_insert_no_match, clock, reset, resp_insert, !rsp_match_found)
   `NKS_ASSERT_IMP(a_shift_wr_inside, clock, reset, shift_wr, CNT_W'(ram_wr_addr) < count_ff)

endmodule
